// ===== src/mcs51_subset_instruction_core_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the instruction core
// implication checks, same cycle and next cycle, switched off by ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef MCS51_SUBSET_INSTRUCTION_CORE_ASSERT_SVH
`define MCS51_SUBSET_INSTRUCTION_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MCS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");
`define MCS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define MCS_ASSERT_IMP(label, clk, rst, pre, post)
`define MCS_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

// ===== src/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcs_pkg
// shared types, opcodes, sfr addresses and address helpers
// ----------------------------------------------------------------------------
package mcs_pkg;

   localparam int unsigned MEM_DEPTH = 256;

   // opcodes
   localparam logic [7:0] OP_NOP       = 8'h00;
   localparam logic [7:0] OP_LJMP      = 8'h02;
   localparam logic [7:0] OP_INC_A     = 8'h04;
   localparam logic [7:0] OP_INC_DIR   = 8'h05;
   localparam logic [7:0] OP_LCALL     = 8'h12;
   localparam logic [7:0] OP_DEC_A     = 8'h14;
   localparam logic [7:0] OP_DEC_DIR   = 8'h15;
   localparam logic [7:0] OP_JB        = 8'h20;
   localparam logic [7:0] OP_RET       = 8'h22;
   localparam logic [7:0] OP_ADD_IMM   = 8'h24;
   localparam logic [7:0] OP_JNB       = 8'h30;
   localparam logic [7:0] OP_RETI      = 8'h32;
   localparam logic [7:0] OP_MOV_A_IMM = 8'h74;
   localparam logic [7:0] OP_MOV_D_IMM = 8'h75;
   localparam logic [7:0] OP_MOV_RN_LO = 8'h78;
   localparam logic [7:0] OP_MOV_RN_HI = 8'h7F;
   localparam logic [7:0] OP_SJMP      = 8'h80;
   localparam logic [7:0] OP_MOV_DPTR  = 8'h90;
   localparam logic [7:0] OP_SUBB_IMM  = 8'h94;
   localparam logic [7:0] OP_CPL_BIT   = 8'hB2;
   localparam logic [7:0] OP_CLR_BIT   = 8'hC2;
   localparam logic [7:0] OP_SETB_BIT  = 8'hD2;
   localparam logic [7:0] OP_DJNZ_DIR  = 8'hD5;
   localparam logic [7:0] OP_DJNZ_LO   = 8'hD8;
   localparam logic [7:0] OP_DJNZ_HI   = 8'hDF;
   localparam logic [7:0] OP_CLR_A     = 8'hE4;
   localparam logic [7:0] OP_MOV_A_DIR = 8'hE5;
   localparam logic [7:0] OP_CPL_A     = 8'hF4;
   localparam logic [7:0] OP_MOV_DIR_A = 8'hF5;

   // sfr addresses
   localparam logic [7:0] ADR_P0  = 8'h80;
   localparam logic [7:0] ADR_SP  = 8'h81;
   localparam logic [7:0] ADR_DPL = 8'h82;
   localparam logic [7:0] ADR_DPH = 8'h83;
   localparam logic [7:0] ADR_P1  = 8'h90;
   localparam logic [7:0] ADR_P2  = 8'hA0;
   localparam logic [7:0] ADR_P3  = 8'hB0;
   localparam logic [7:0] ADR_PSW = 8'hD0;
   localparam logic [7:0] ADR_ACC = 8'hE0;
   localparam logic [7:0] ADR_B   = 8'hF0;

   localparam logic [7:0] BIT_BYTE_MASK = 8'hF8;
   localparam logic [7:0] SP_RESET      = 8'h07;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] b;
      logic [7:0] psw;
      logic [7:0] sp;
      logic [7:0] dpl;
      logic [7:0] dph;
   } core_regs_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic       chg;
      logic [1:0] num;
      logic [7:0] val;
   } port_evt_type;

   typedef struct packed {
      logic [15:0]  next_pc;
      logic         status;
      logic [1:0]   machine_cycles;
      core_regs_type regs;
      port_evt_type port;
   } rsp_type;

   // registers held in flops rather than in the memory
   function automatic logic is_core(input logic [7:0] addr);
      return (addr == ADR_SP) || (addr == ADR_DPL) || (addr == ADR_DPH) ||
             (addr == ADR_PSW) || (addr == ADR_ACC) || (addr == ADR_B);
   endfunction

   function automatic logic is_port(input logic [7:0] addr);
      return (addr == ADR_P0) || (addr == ADR_P1) || (addr == ADR_P2) || (addr == ADR_P3);
   endfunction

   // first read address of an instruction
   function automatic logic [7:0] rd_addr_a(input logic [7:0] op, input logic [7:0] b1,
                                            input logic [7:0] psw, input logic [7:0] sp);
      logic [7:0] a;
      unique case (op) inside
         OP_LCALL:                                      a = sp + 8'd1;
         OP_RET, OP_RETI:                               a = sp;
         [OP_MOV_RN_LO:OP_MOV_RN_HI], [OP_DJNZ_LO:OP_DJNZ_HI]:
                                                        a = {3'b000, psw[4:3], op[2:0]};
         OP_CLR_BIT, OP_SETB_BIT, OP_CPL_BIT, OP_JB, OP_JNB:
                                                        a = b1 & BIT_BYTE_MASK;
         default:                                       a = b1;
      endcase
      return a;
   endfunction

   // second read address: second push target or second pop source
   function automatic logic [7:0] rd_addr_b(input logic [7:0] op, input logic [7:0] sp,
                                            input logic [15:0] pc);
      logic [7:0]  a1;
      logic [15:0] ret;
      logic [7:0]  a;
      a1  = sp + 8'd1;
      ret = pc + 16'd3;
      unique case (op) inside
         OP_LCALL:        a = ((a1 == ADR_SP) ? ret[7:0] : a1) + 8'd1;
         OP_RET, OP_RETI: a = sp - 8'd1;
         default:         a = sp;
      endcase
      return a;
   endfunction

endpackage

// ===== src/mcs_req_if.sv =====
// ----------------------------------------------------------------------------
// mcs_req_if
// instruction channel: opcode and the two following code bytes
// ----------------------------------------------------------------------------
interface mcs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] opcode;
   logic [7:0] operand_one;
   logic [7:0] operand_two;

   modport source (output valid, opcode, operand_one, operand_two, input ready);
   modport sink   (input valid, opcode, operand_one, operand_two, output ready);
endinterface

// ===== src/mcs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mcs_rsp_if
// result channel: next pc, status and core register snapshot
// ----------------------------------------------------------------------------
interface mcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_pc;
   logic        status;
   logic [1:0]  machine_cycles;
   logic [7:0]  acc_value;
   logic [7:0]  b_value;
   logic [7:0]  flags_value;
   logic [7:0]  stack_ptr;
   logic [15:0] data_ptr;
   logic        port_changed;
   logic [1:0]  port_number;
   logic [7:0]  port_value;

   modport source (output valid, next_pc, status, machine_cycles, acc_value, b_value,
                   flags_value, stack_ptr, data_ptr, port_changed, port_number,
                   port_value, input ready);
   modport sink   (input valid, next_pc, status, machine_cycles, acc_value, b_value,
                   flags_value, stack_ptr, data_ptr, port_changed, port_number,
                   port_value, output ready);
endinterface

// ===== src/mcs_ram.sv =====
// ----------------------------------------------------------------------------
// mcs_ram
// direct-address memory, 256 bytes, two registered reads, one write
// ----------------------------------------------------------------------------
module mcs_ram (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [7:0]         rd_addr_a,
   input  logic [7:0]         rd_addr_b,
   input  mcs_pkg::mem_wr_type wr,
   output logic [7:0]         rd_data_a,
   output logic [7:0]         rd_data_b
);
   import mcs_pkg::*;

   logic [7:0]           mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic [MEM_DEPTH-1:0] vld_in;
   logic [7:0]           dat_a_ff;
   logic [7:0]           dat_b_ff;
   logic                 va_ff;
   logic                 vb_ff;

   // a never-written byte reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         dat_a_ff <= mem_ff[rd_addr_a];
         dat_b_ff <= mem_ff[rd_addr_b];
         va_ff    <= vld_ff[rd_addr_a];
         vb_ff    <= vld_ff[rd_addr_b];
      end
   end

   assign rd_data_a = va_ff ? dat_a_ff : 8'd0;
   assign rd_data_b = vb_ff ? dat_b_ff : 8'd0;

endmodule

// ===== src/mcs_alu.sv =====
// ----------------------------------------------------------------------------
// mcs_alu
// execute step: decode, arithmetic, branch target and write-back request
// ----------------------------------------------------------------------------
module mcs_alu (
   input  logic [7:0]            op,
   input  logic [7:0]            b1,
   input  logic [7:0]            b2,
   input  logic [15:0]           pc,
   input  logic                  phase,
   input  mcs_pkg::core_regs_type regs,
   input  mcs_pkg::port_evt_type pend_port,
   input  logic [7:0]            rd_data_a,
   input  logic [7:0]            rd_data_b,
   output mcs_pkg::core_regs_type nregs,
   output logic [15:0]           npc,
   output mcs_pkg::mem_wr_type   mwr,
   output mcs_pkg::port_evt_type port_out,
   output logic                  status,
   output logic [1:0]            cycles,
   output logic                  final_ph
);
   import mcs_pkg::*;

   function automatic logic [7:0] core_val(input logic [7:0] addr, input core_regs_type r);
      logic [7:0] v;
      case (addr)
         ADR_SP:  v = r.sp;
         ADR_DPL: v = r.dpl;
         ADR_DPH: v = r.dph;
         ADR_PSW: v = r.psw;
         ADR_ACC: v = r.acc;
         ADR_B:   v = r.b;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   function automatic logic [15:0] rel(input logic [15:0] base, input logic [7:0] off);
      return base + {{8{off[7]}}, off};
   endfunction

   always_comb begin
      logic [7:0]  addr_a;
      logic [7:0]  va;
      logic [7:0]  v;
      logic [7:0]  lo_addr;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [15:0] ret;
      logic [8:0]  wide;
      logic [4:0]  nib;
      logic        cy;
      logic        wr_en;
      logic [7:0]  wr_addr;
      logic [7:0]  wr_data;
      logic [7:0]  wr_old;

      addr_a   = rd_addr_a(op, b1, regs.psw, regs.sp);
      va       = is_core(addr_a) ? core_val(addr_a, regs) : rd_data_a;
      nregs    = regs;
      npc      = pc + 16'd1;
      status   = 1'b0;
      final_ph = 1'b1;
      port_out = pend_port;
      wr_en    = 1'b0;
      wr_addr  = addr_a;
      wr_data  = 8'd0;
      wr_old   = rd_data_a;
      ret      = pc + 16'd3;
      v        = 8'd0;
      lo_addr  = regs.sp - 8'd1;
      hi       = 8'd0;
      lo       = 8'd0;
      wide     = 9'd0;
      nib      = 5'd0;
      cy       = regs.psw[7];

      unique case (op) inside
         OP_NOP: ;
         OP_LJMP: npc = {b1, b2};
         OP_LCALL: begin
            // low byte first, then high byte after the pointer has moved
            nregs.sp = regs.sp + 8'd1;
            wr_en    = 1'b1;
            wr_addr  = regs.sp + 8'd1;
            if (!phase) begin
               final_ph = 1'b0;
               wr_data  = ret[7:0];
            end else begin
               wr_data = ret[15:8];
               wr_old  = rd_data_b;
               npc     = {b1, b2};
            end
         end
         OP_RET, OP_RETI: begin
            hi = is_core(regs.sp) ? core_val(regs.sp, regs) : rd_data_a;
            if (lo_addr == ADR_SP) begin
               lo = lo_addr;
            end else if (is_core(lo_addr)) begin
               lo = core_val(lo_addr, regs);
            end else begin
               lo = rd_data_b;
            end
            nregs.sp = regs.sp - 8'd2;
            npc      = {hi, lo};
         end
         OP_SJMP: npc = rel(pc + 16'd2, b1);
         OP_MOV_DPTR: begin
            nregs.dph = b1;
            nregs.dpl = b2;
            npc       = ret;
         end
         OP_MOV_A_IMM: begin
            nregs.acc = b1;
            npc       = pc + 16'd2;
         end
         OP_MOV_D_IMM: begin
            wr_en   = 1'b1;
            wr_data = b2;
            npc     = ret;
         end
         [OP_MOV_RN_LO:OP_MOV_RN_HI]: begin
            wr_en   = 1'b1;
            wr_data = b1;
            npc     = pc + 16'd2;
         end
         OP_MOV_A_DIR: begin
            nregs.acc = va;
            npc       = pc + 16'd2;
         end
         OP_MOV_DIR_A: begin
            wr_en   = 1'b1;
            wr_data = regs.acc;
            npc     = pc + 16'd2;
         end
         OP_INC_A: nregs.acc = regs.acc + 8'd1;
         OP_DEC_A: nregs.acc = regs.acc - 8'd1;
         OP_INC_DIR, OP_DEC_DIR: begin
            wr_en   = 1'b1;
            wr_data = (op == OP_INC_DIR) ? va + 8'd1 : va - 8'd1;
            npc     = pc + 16'd2;
         end
         OP_DJNZ_DIR: begin
            v       = va - 8'd1;
            wr_en   = 1'b1;
            wr_data = v;
            npc     = (v != 8'd0) ? rel(ret, b2) : ret;
         end
         [OP_DJNZ_LO:OP_DJNZ_HI]: begin
            v       = va - 8'd1;
            wr_en   = 1'b1;
            wr_data = v;
            npc     = (v != 8'd0) ? rel(pc + 16'd2, b1) : pc + 16'd2;
         end
         OP_ADD_IMM: begin
            wide      = {1'b0, regs.acc} + {1'b0, b1};
            nib       = {1'b0, regs.acc[3:0]} + {1'b0, b1[3:0]};
            nregs.acc = wide[7:0];
            nregs.psw = {wide[8], nib[4], regs.psw[5:3],
                         ~(regs.acc[7] ^ b1[7]) & (regs.acc[7] ^ wide[7]), regs.psw[1:0]};
            npc       = pc + 16'd2;
         end
         OP_SUBB_IMM: begin
            wide      = {1'b0, regs.acc} - {1'b0, b1} - {8'd0, cy};
            nib       = {1'b0, regs.acc[3:0]} - {1'b0, b1[3:0]} - {4'd0, cy};
            nregs.acc = wide[7:0];
            nregs.psw = {wide[8], nib[4], regs.psw[5:3],
                         (regs.acc[7] ^ b1[7]) & (regs.acc[7] ^ wide[7]), regs.psw[1:0]};
            npc       = pc + 16'd2;
         end
         OP_CLR_A: nregs.acc = 8'd0;
         OP_CPL_A: nregs.acc = ~regs.acc;
         OP_CLR_BIT, OP_SETB_BIT, OP_CPL_BIT: begin
            v = 8'd1 << b1[2:0];
            wr_en = 1'b1;
            if (op == OP_CLR_BIT) begin
               wr_data = va & ~v;
            end else if (op == OP_SETB_BIT) begin
               wr_data = va | v;
            end else begin
               wr_data = va ^ v;
            end
            npc = pc + 16'd2;
         end
         OP_JB, OP_JNB: begin
            npc = ((op == OP_JB) == va[b1[2:0]]) ? rel(ret, b2) : ret;
         end
         default: status = 1'b1;
      endcase

      // write-back: core registers go to flops, the rest to memory
      mwr = '{en: 1'b0, addr: wr_addr, data: wr_data};
      if (wr_en) begin
         if (is_core(wr_addr)) begin
            case (wr_addr)
               ADR_SP:  nregs.sp  = wr_data;
               ADR_DPL: nregs.dpl = wr_data;
               ADR_DPH: nregs.dph = wr_data;
               ADR_PSW: nregs.psw = wr_data;
               ADR_ACC: nregs.acc = wr_data;
               ADR_B:   nregs.b   = wr_data;
               default: ;
            endcase
         end else begin
            mwr.en = 1'b1;
         end
         if (is_port(wr_addr) && (wr_old != wr_data)) begin
            port_out = '{chg: 1'b1, num: wr_addr[5:4], val: wr_data};
         end
      end

      if (!status && final_ph) begin
         nregs.psw[0] = ^nregs.acc;
      end

      unique case (op) inside
         OP_NOP, OP_INC_A, OP_DEC_A, OP_ADD_IMM, OP_SUBB_IMM, OP_CLR_A, OP_CPL_A:
            cycles = 2'd1;
         default:
            cycles = 2'd2;
      endcase
   end

endmodule

// ===== src/mcs51_subset_instruction_core.sv =====
// ----------------------------------------------------------------------------
// mcs51_subset_instruction_core
// one 8051-subset instruction per request transfer, one result per instruction
// ----------------------------------------------------------------------------
// In the cycle of its request transfer an instruction's operand bytes are read from
// a 256-byte direct-address memory (registered); in the next cycle it executes, and
// it writes back once the output register can take its result. LCALL makes its two
// pushes one after the other, sharing the single memory write port. A new request
// transfer is taken as soon as the previous instruction has written back, even
// while its result still waits in the output register. ACC, B, PSW, SP and DPTR
// sit in flops; every other SFR and the internal RAM share the memory, whose bytes
// read as zero until first written (per-byte valid bits, no clearing pass).
// ----------------------------------------------------------------------------
`include "mcs51_subset_instruction_core_assert.svh"

module mcs51_subset_instruction_core (
   input logic       clock,
   input logic       reset,
   mcs_req_if.sink   req_chan,
   mcs_rsp_if.source rsp_chan
);
   import mcs_pkg::*;

   // architectural state
   logic [15:0]   pc_ff,    pc_in;
   core_regs_type regs_ff,  regs_in;

   // instruction in flight
   logic          busy_ff,  busy_in;
   logic          phase_ff, phase_in;
   logic [7:0]    op_ff, b1_ff, b2_ff;
   port_evt_type  port_ff,  port_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          acc_req;
   logic          slot_free;
   logic          commit;
   logic [7:0]    rd_data_a, rd_data_b;
   core_regs_type nregs;
   logic [15:0]   npc;
   mem_wr_type    mwr;
   mem_wr_type    mwr_gated;
   port_evt_type  port_out;
   port_evt_type  pend_port;
   logic          status;
   logic [1:0]    cycles;
   logic          final_ph;

   // take a new instruction once the previous one has written back
   assign req_chan.ready = !busy_ff;
   assign acc_req        = req_chan.valid && !busy_ff;
   // result slot empty, or emptied by a transfer this cycle
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   // first lcall push never needs the slot; the last step waits for it
   assign commit         = busy_ff && (!final_ph || slot_free);
   assign pend_port      = phase_ff ? port_ff : '0;
   assign mwr_gated      = '{en: mwr.en && commit, addr: mwr.addr, data: mwr.data};

   mcs_ram u_ram (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (acc_req),
      .rd_addr_a (rd_addr_a(req_chan.opcode, req_chan.operand_one, regs_ff.psw, regs_ff.sp)),
      .rd_addr_b (rd_addr_b(req_chan.opcode, regs_ff.sp, pc_ff)),
      .wr        (mwr_gated),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   mcs_alu u_alu (
      .op        (op_ff),
      .b1        (b1_ff),
      .b2        (b2_ff),
      .pc        (pc_ff),
      .phase     (phase_ff),
      .regs      (regs_ff),
      .pend_port (pend_port),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .nregs     (nregs),
      .npc       (npc),
      .mwr       (mwr),
      .port_out  (port_out),
      .status    (status),
      .cycles    (cycles),
      .final_ph  (final_ph)
   );

   always_comb begin
      busy_in      = busy_ff;
      phase_in     = phase_ff;
      regs_in      = regs_ff;
      pc_in        = pc_ff;
      port_in      = port_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      // result leaves on a transfer
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (acc_req) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
      end
      if (commit) begin
         regs_in  = nregs;
         port_in  = port_out;
         phase_in = !final_ph;
         if (final_ph) begin
            busy_in      = 1'b0;
            pc_in        = npc;
            rsp_valid_in = 1'b1;
            rsp_in       = '{next_pc: npc, status: status, machine_cycles: cycles,
                             regs: nregs, port: port_out};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= 16'd0;
         regs_ff      <= '{acc: 8'd0, b: 8'd0, psw: 8'd0, sp: SP_RESET, dpl: 8'd0, dph: 8'd0};
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         pc_ff        <= pc_in;
         regs_ff      <= regs_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (acc_req) begin
         op_ff <= req_chan.opcode;
         b1_ff <= req_chan.operand_one;
         b2_ff <= req_chan.operand_two;
      end
      port_ff <= port_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.next_pc        = rsp_ff.next_pc;
   assign rsp_chan.status         = rsp_ff.status;
   assign rsp_chan.machine_cycles = rsp_ff.machine_cycles;
   assign rsp_chan.acc_value      = rsp_ff.regs.acc;
   assign rsp_chan.b_value        = rsp_ff.regs.b;
   assign rsp_chan.flags_value    = rsp_ff.regs.psw;
   assign rsp_chan.stack_ptr      = rsp_ff.regs.sp;
   assign rsp_chan.data_ptr       = {rsp_ff.regs.dph, rsp_ff.regs.dpl};
   assign rsp_chan.port_changed   = rsp_ff.port.chg;
   assign rsp_chan.port_number    = rsp_ff.port.num;
   assign rsp_chan.port_value     = rsp_ff.port.val;

   // an accepted instruction is in flight on the next cycle
   `MCS_ASSERT_NXT(a_accept_busy, clock, reset, acc_req, busy_ff)
   // a result is only loaded into a free slot
   `MCS_ASSERT_IMP(a_slot_free, clock, reset, commit && final_ph, slot_free)
   // lcall second push follows its first without a new request
   `MCS_ASSERT_NXT(a_lcall_phase, clock, reset, commit && !final_ph, busy_ff && phase_ff)
   // unknown opcodes are charged two machine cycles
   `MCS_ASSERT_IMP(a_unimpl_cycles, clock, reset, rsp_valid_ff && rsp_ff.status,
                   rsp_ff.machine_cycles == 2'd2)

endmodule

// ===== verif/tb_mcs51_subset_instruction_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mcs51_subset_instruction_core
// drives instruction transfers with random idle gaps and result stalls, keeps
// its own copy of ram, sfr window and pc, and checks every result transfer
// field by field against the predicted instruction outcome
// ----------------------------------------------------------------------------
module tb_mcs51_subset_instruction_core;
   import mcs_pkg::*;

   localparam logic [7:0] FL_CY = 8'h80;
   localparam logic [7:0] FL_AC = 8'h40;
   localparam logic [7:0] FL_OV = 8'h04;
   localparam logic [7:0] FL_P  = 8'h01;

   logic clock;
   logic reset;

   mcs_req_if req_chan ();
   mcs_rsp_if rsp_chan ();

   mcs51_subset_instruction_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // predicted core state
   logic [7:0]  model_ram [128];
   logic [7:0]  model_sfr [128];
   logic [15:0] model_pc;
   logic        evt_chg;
   logic [1:0]  evt_num;
   logic [7:0]  evt_val;

   rsp_type expected_rsp_q [$];
   int unsigned mismatch_count;
   int unsigned instr_sent;

   function automatic logic [7:0] sfr_rd(input logic [7:0] addr);
      return model_sfr[addr[6:0]];
   endfunction

   function automatic void sfr_wr(input logic [7:0] addr, input logic [7:0] v);
      model_sfr[addr[6:0]] = v;
   endfunction

   function automatic logic [7:0] direct_rd(input logic [7:0] addr);
      return addr[7] ? model_sfr[addr[6:0]] : model_ram[addr[6:0]];
   endfunction

   function automatic void direct_wr(input logic [7:0] addr, input logic [7:0] v);
      logic [7:0] old;
      if (!addr[7]) begin
         model_ram[addr[6:0]] = v;
      end else begin
         old = model_sfr[addr[6:0]];
         model_sfr[addr[6:0]] = v;
         // port latch write is only reported when the value really changes
         if (is_port(addr) && old != v) begin
            evt_chg = 1'b1;
            evt_num = addr[5:4];
            evt_val = v;
         end
      end
   endfunction

   function automatic logic [6:0] bank_addr(input logic [7:0] op);
      logic [7:0] psw;
      psw = sfr_rd(ADR_PSW);
      return {2'b00, psw[4:3], op[2:0]};
   endfunction

   function automatic void push_byte(input logic [7:0] v);
      logic [7:0] sp;
      sp = sfr_rd(ADR_SP) + 8'd1;
      sfr_wr(ADR_SP, sp);
      direct_wr(sp, v);
   endfunction

   function automatic logic [7:0] pop_byte();
      logic [7:0] v;
      v = direct_rd(sfr_rd(ADR_SP));
      sfr_wr(ADR_SP, sfr_rd(ADR_SP) - 8'd1);
      return v;
   endfunction

   function automatic logic [15:0] branch_dest(input logic [15:0] pc, input logic [7:0] rel);
      return pc + {{8{rel[7]}}, rel};
   endfunction

   function automatic void reset_model();
      foreach (model_ram[i]) model_ram[i] = 8'h00;
      foreach (model_sfr[i]) model_sfr[i] = 8'h00;
      sfr_wr(ADR_SP, SP_RESET);
      model_pc = 16'h0000;
   endfunction

   // executes one instruction on the model and returns the expected result
   function automatic rsp_type execute_instr(input logic [7:0] op, input logic [7:0] b1,
                                             input logic [7:0] b2);
      rsp_type     r;
      logic [15:0] pc;
      logic [7:0]  a, v, m, psw, res, hi, lo;
      logic [8:0]  wide;
      logic        ok, cy;
      logic [4:0]  nib;
      pc = model_pc;
      a  = sfr_rd(ADR_ACC);
      ok = 1'b1;
      evt_chg = 1'b0; evt_num = 2'd0; evt_val = 8'h00;
      case (op) inside
         OP_NOP:   pc = pc + 16'd1;
         OP_LJMP:  pc = {b1, b2};
         OP_LCALL: begin
            push_byte(pc[7:0] + 8'd3);
            wide = {1'b0, pc[7:0]} + 9'd3;
            push_byte(pc[15:8] + {7'd0, wide[8]});
            pc = {b1, b2};
         end
         OP_RET, OP_RETI: begin
            hi = pop_byte();
            lo = pop_byte();
            pc = {hi, lo};
         end
         OP_SJMP:      pc = branch_dest(pc + 16'd2, b1);
         OP_MOV_DPTR: begin
            sfr_wr(ADR_DPH, b1); sfr_wr(ADR_DPL, b2); pc = pc + 16'd3;
         end
         OP_MOV_A_IMM: begin sfr_wr(ADR_ACC, b1); pc = pc + 16'd2; end
         OP_MOV_D_IMM: begin direct_wr(b1, b2); pc = pc + 16'd3; end
         [OP_MOV_RN_LO:OP_MOV_RN_HI]: begin
            model_ram[bank_addr(op)] = b1; pc = pc + 16'd2;
         end
         OP_MOV_A_DIR: begin sfr_wr(ADR_ACC, direct_rd(b1)); pc = pc + 16'd2; end
         OP_MOV_DIR_A: begin direct_wr(b1, a); pc = pc + 16'd2; end
         OP_INC_A:     begin sfr_wr(ADR_ACC, a + 8'd1); pc = pc + 16'd1; end
         OP_DEC_A:     begin sfr_wr(ADR_ACC, a - 8'd1); pc = pc + 16'd1; end
         OP_INC_DIR:   begin direct_wr(b1, direct_rd(b1) + 8'd1); pc = pc + 16'd2; end
         OP_DEC_DIR:   begin direct_wr(b1, direct_rd(b1) - 8'd1); pc = pc + 16'd2; end
         OP_DJNZ_DIR: begin
            v = direct_rd(b1) - 8'd1;
            direct_wr(b1, v);
            pc = pc + 16'd3;
            if (v != 8'h00) pc = branch_dest(pc, b2);
         end
         [OP_DJNZ_LO:OP_DJNZ_HI]: begin
            v = model_ram[bank_addr(op)] - 8'd1;
            model_ram[bank_addr(op)] = v;
            pc = pc + 16'd2;
            if (v != 8'h00) pc = branch_dest(pc, b1);
         end
         OP_ADD_IMM: begin
            wide = {1'b0, a} + {1'b0, b1};
            res  = wide[7:0];
            psw  = sfr_rd(ADR_PSW) & ~(FL_CY | FL_AC | FL_OV);
            nib  = {1'b0, a[3:0]} + {1'b0, b1[3:0]};
            if (nib[4]) psw |= FL_AC;
            if (wide[8]) psw |= FL_CY;
            if (~(a[7] ^ b1[7]) & (a[7] ^ res[7])) psw |= FL_OV;
            sfr_wr(ADR_PSW, psw); sfr_wr(ADR_ACC, res);
            pc = pc + 16'd2;
         end
         OP_SUBB_IMM: begin
            psw  = sfr_rd(ADR_PSW);
            cy   = psw[7];
            wide = {1'b0, a} - {1'b0, b1} - {8'd0, cy};
            res  = wide[7:0];
            psw  = psw & ~(FL_CY | FL_AC | FL_OV);
            nib  = {1'b0, a[3:0]} - {1'b0, b1[3:0]} - {4'd0, cy};
            if (nib[4]) psw |= FL_AC;
            if (wide[8]) psw |= FL_CY;
            if ((a[7] ^ b1[7]) & (a[7] ^ res[7])) psw |= FL_OV;
            sfr_wr(ADR_PSW, psw); sfr_wr(ADR_ACC, res);
            pc = pc + 16'd2;
         end
         OP_CLR_A: begin sfr_wr(ADR_ACC, 8'h00); pc = pc + 16'd1; end
         OP_CPL_A: begin sfr_wr(ADR_ACC, ~a); pc = pc + 16'd1; end
         OP_CLR_BIT, OP_SETB_BIT, OP_CPL_BIT: begin
            // bit address selects byte (addr and f8), also in internal ram
            m = 8'h01 << b1[2:0];
            v = direct_rd(b1 & BIT_BYTE_MASK);
            if (op == OP_CLR_BIT)       v = v & ~m;
            else if (op == OP_SETB_BIT) v = v | m;
            else                        v = v ^ m;
            direct_wr(b1 & BIT_BYTE_MASK, v);
            pc = pc + 16'd2;
         end
         OP_JB, OP_JNB: begin
            v  = direct_rd(b1 & BIT_BYTE_MASK);
            pc = pc + 16'd3;
            if (v[b1[2:0]] == (op == OP_JB)) pc = branch_dest(pc, b2);
         end
         default: begin
            ok = 1'b0;
            pc = pc + 16'd1;
         end
      endcase
      // parity follows the accumulator after every executed instruction
      if (ok) begin
         psw = sfr_rd(ADR_PSW);
         sfr_wr(ADR_PSW, (psw & ~FL_P) | {7'd0, ^sfr_rd(ADR_ACC)});
      end
      model_pc = pc;
      r.next_pc        = pc;
      r.status         = ~ok;
      r.machine_cycles = (op inside {OP_NOP, OP_INC_A, OP_DEC_A, OP_ADD_IMM, OP_SUBB_IMM,
                                     OP_CLR_A, OP_CPL_A}) ? 2'd1 : 2'd2;
      r.regs.acc = sfr_rd(ADR_ACC);
      r.regs.b   = sfr_rd(ADR_B);
      r.regs.psw = sfr_rd(ADR_PSW);
      r.regs.sp  = sfr_rd(ADR_SP);
      r.regs.dpl = sfr_rd(ADR_DPL);
      r.regs.dph = sfr_rd(ADR_DPH);
      r.port.chg = evt_chg;
      r.port.num = evt_num;
      r.port.val = evt_val;
      return r;
   endfunction

   // one instruction transfer after a random idle gap; prediction made on acceptance
   task automatic send_instr(input logic [7:0] op, input logic [7:0] b1,
                             input logic [7:0] b2);
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 1) == 0) gap = 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= op;
      req_chan.operand_one <= b1;
      req_chan.operand_two <= b2;
      do @(posedge clock); while (!req_chan.ready);
      expected_rsp_q.push_back(execute_instr(op, b1, b2));
      instr_sent++;
   endtask

   // result sink: random stall per result, then compare with oldest prediction
   initial begin
      rsp_type got, exp_r;
      int unsigned stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.next_pc        = rsp_chan.next_pc;
         got.status         = rsp_chan.status;
         got.machine_cycles = rsp_chan.machine_cycles;
         got.regs.acc       = rsp_chan.acc_value;
         got.regs.b         = rsp_chan.b_value;
         got.regs.psw       = rsp_chan.flags_value;
         got.regs.sp        = rsp_chan.stack_ptr;
         got.regs.dph       = rsp_chan.data_ptr[15:8];
         got.regs.dpl       = rsp_chan.data_ptr[7:0];
         got.port.chg       = rsp_chan.port_changed;
         got.port.num       = rsp_chan.port_number;
         got.port.val       = rsp_chan.port_value;
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result transfer: %p", got);
         end else begin
            exp_r = expected_rsp_q.pop_front();
            if (got !== exp_r) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch\n  expected %p\n  actual   %p", exp_r, got);
            end
         end
      end
   end

   // ---- test tasks ----

   // a selection of supported opcodes with field extremes and the named corner cases
   task automatic test_directed();
      send_instr(OP_NOP, 8'h00, 8'h00);
      send_instr(OP_MOV_A_IMM, 8'hFF, 8'h00);          // parity of acc
      send_instr(OP_ADD_IMM, 8'h01, 8'hFF);            // carry, aux carry
      send_instr(OP_ADD_IMM, 8'h7F, 8'h00);            // overflow flag clear
      send_instr(OP_SUBB_IMM, 8'hFF, 8'h00);           // borrow out
      send_instr(OP_SUBB_IMM, 8'h80, 8'h00);
      send_instr(OP_CPL_A, 8'h00, 8'h00);
      send_instr(OP_INC_A, 8'h00, 8'h00);
      send_instr(OP_DEC_A, 8'h00, 8'h00);
      send_instr(OP_CLR_A, 8'h00, 8'h00);
      send_instr(OP_MOV_DPTR, 8'hFF, 8'hFF);
      send_instr(OP_MOV_D_IMM, ADR_P1, 8'hA5);         // port latch change
      send_instr(OP_MOV_D_IMM, ADR_P1, 8'hA5);         // same value, no change
      send_instr(OP_MOV_D_IMM, ADR_PSW, 8'h18);        // bank 3, direct psw write
      send_instr(8'h7F, 8'h01, 8'h00);                 // r7 of bank 3
      send_instr(8'hDF, 8'hFE, 8'h00);                 // djnz reaches zero
      send_instr(OP_DJNZ_DIR, 8'h00, 8'h80);           // wraps to ff, branches back
      send_instr(OP_SETB_BIT, 8'h07, 8'h00);           // bit address below 80
      send_instr(OP_JB, 8'h07, 8'h7F);
      send_instr(OP_CPL_BIT, ADR_P3 | 8'h07, 8'h00);
      send_instr(OP_JNB, ADR_ACC, 8'h80);
      send_instr(OP_MOV_D_IMM, ADR_SP, 8'h7F);         // stack crosses into sfr window
      send_instr(OP_LCALL, 8'hFF, 8'hFE);              // return address pushed into the sfr window
      send_instr(OP_RETI, 8'h00, 8'h00);
      send_instr(8'hA5, 8'hFF, 8'hFF);                 // unimplemented
      send_instr(OP_LJMP, 8'h00, 8'h00);
   endtask

   // random instructions, mostly supported opcodes over interesting addresses
   task automatic test_random(input int unsigned count);
      logic [7:0] op, b1, b2;
      logic [7:0] ops [30];
      logic [7:0] hot [12];
      ops = '{OP_NOP, OP_LJMP, OP_INC_A, OP_INC_DIR, OP_LCALL, OP_DEC_A, OP_DEC_DIR, OP_JB,
              OP_RET, OP_ADD_IMM, OP_JNB, OP_RETI, OP_MOV_A_IMM, OP_MOV_D_IMM, 8'h7A,
              OP_SJMP, OP_MOV_DPTR, OP_SUBB_IMM, OP_CPL_BIT, OP_CLR_BIT, OP_SETB_BIT,
              OP_DJNZ_DIR, 8'hDB, OP_CLR_A, OP_MOV_A_DIR, OP_CPL_A, OP_MOV_DIR_A,
              OP_MOV_D_IMM, OP_SETB_BIT, OP_MOV_DIR_A};
      hot = '{ADR_P0, ADR_SP, ADR_DPL, ADR_DPH, ADR_P1, ADR_P2, ADR_P3, ADR_PSW, ADR_ACC,
              ADR_B, 8'h08, 8'h7F};
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) op = 8'($urandom_range(0, 255));
         else if ($urandom_range(0, 3) == 0) op = {5'b11011, 3'($urandom_range(0, 7))} ^
                                                   (($urandom_range(0, 1) != 0) ? 8'hA0 : 8'h00);
         else op = ops[$urandom_range(0, 29)];
         b1 = ($urandom_range(0, 2) == 0) ? hot[$urandom_range(0, 11)] ^ 8'($urandom_range(0, 7))
                                           : 8'($urandom_range(0, 255));
         b2 = 8'($urandom_range(0, 255));
         send_instr(op, b1, b2);
      end
   endtask

   initial begin : limit_timer
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int unsigned drain;
      reset = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.opcode      = 8'h00;
      req_chan.operand_one = 8'h00;
      req_chan.operand_two = 8'h00;
      mismatch_count = 0;
      instr_sent = 0;
      reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(850);
      req_chan.valid <= 1'b0;
      drain = 0;
      while (expected_rsp_q.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
